// ----- hw/rtl/ngram_match_counter_core_defines.svh -----
// ----------------------------------------------------------------------------
// ngram match counter assertion macros
// shared property templates for the n-gram match counter rtl
// ----------------------------------------------------------------------------
`ifndef NGRAM_MATCH_COUNTER_CORE_DEFINES_SVH
`define NGRAM_MATCH_COUNTER_CORE_DEFINES_SVH

// same-cycle implication, checked on every clock edge out of reset
`define NMC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/nmc_pkg.sv -----
// ----------------------------------------------------------------------------
// nmc_pkg
// constants shared by the n-gram match counter rtl
// ----------------------------------------------------------------------------
package nmc_pkg;

	// configuration register
	localparam int CFG_W = 4;
	localparam logic [CFG_W-1:0] MAX_ORDER_RESET = 4'd4;

	// token source codes
	localparam logic MODE_TRANSLATION = 1'b0;
	localparam logic MODE_REFERENCE   = 1'b1;

	typedef logic [2:0] state_t;

endpackage

// ----- hw/rtl/ngram_match_counter_core.sv -----
// ----------------------------------------------------------------------------
// ngram_match_counter_core
// clipped n-gram match counts of a translation against a reference
// ----------------------------------------------------------------------------
// usage:
//  - tokens enter on start while busy is low, one per cycle. mode selects the
//    translation store or the reference store. tokens past MAX_LEN are dropped
//    and flagged on the results.
//  - a reference token with end_of_sequence starts evaluation. busy stays high
//    until the cycle that shows the last result of the pair, and is low there.
//  - for every order n up to min(max_order, tlen-1, rlen-1) one result is
//    strobed on result_valid for a single cycle; last_result marks the final
//    one. a pair with either length below two gives one result of order zero.
//  - evaluation: a setup step, then per order n a clear sweep over the rlen
//    used marks plus token compare steps, each a read state and a check
//    state; at most (tlen+1-n)*(rlen+1-n)*n compare steps per order. the
//    single shared token comparator and the one read port per store set this bound.
//  - max_order is written through cfg_we/cfg_wdata while the block is idle.
//  - the receiver cannot stall: results are transferred in the cycle shown.
//  - reset clears counts, flags and the sequencer and loads max_order with 4;
//    store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`include "ngram_match_counter_core_defines.svh"

module ngram_match_counter_core #(
	parameter int MAX_LEN    = 256,
	parameter int TOKEN_BITS = 20,
	parameter int MAX_ORDER  = 8,
	localparam int LEN_W = $clog2(MAX_LEN + 1),
	localparam int ORD_W = $clog2(MAX_ORDER + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      cfg_we,
	input  logic [nmc_pkg::CFG_W-1:0] cfg_wdata,
	// token input
	input  logic                      start,
	output logic                      busy,
	input  logic                      mode,
	input  logic [TOKEN_BITS-1:0]     token,
	input  logic                      end_of_sequence,
	// results
	output logic                      result_valid,
	output logic [ORD_W-1:0]          order,
	output logic [LEN_W-1:0]          matched_count,
	output logic [LEN_W-1:0]          ngram_count,
	output logic [LEN_W-1:0]          translation_length,
	output logic [LEN_W-1:0]          reference_length,
	output logic                      overflowed,
	output logic                      last_result
);

	localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int LW1 = LEN_W + 1;

	localparam nmc_pkg::state_t ST_IDLE  = 3'd0;
	localparam nmc_pkg::state_t ST_SETUP = 3'd1;
	localparam nmc_pkg::state_t ST_CLR   = 3'd2;
	localparam nmc_pkg::state_t ST_RD    = 3'd3;
	localparam nmc_pkg::state_t ST_CHK   = 3'd4;

	nmc_pkg::state_t state_q;

	logic [nmc_pkg::CFG_W-1:0] max_order_q;
	logic [LEN_W-1:0]          tl_q, rl_q;
	logic                      ovf_q;
	logic [ORD_W-1:0]          eff_q, n_q, p_q;
	logic [AW-1:0]             i_q, j_q, clr_q;
	logic [LEN_W-1:0]          hits_q;

	logic [TOKEN_BITS-1:0] t_mem [MAX_LEN];
	logic [TOKEN_BITS-1:0] r_mem [MAX_LEN];
	logic                  u_mem [MAX_LEN];
	logic [TOKEN_BITS-1:0] t_rd_q, r_rd_q;
	logic                  u_rd_q;

	logic            accept;
	logic            t_wr, r_wr;
	logic [AW-1:0]   t_ra, r_ra;
	logic            u_we, u_wd;
	logic [AW-1:0]   u_wa;
	logic [ORD_W-1:0] eff_calc;
	logic            mismatch, p_last, j_last, i_last, hit_now, clr_last;
	logic [LEN_W-1:0] hits_nxt, grams;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign t_wr   = accept && (mode == nmc_pkg::MODE_TRANSLATION) && (tl_q < LEN_W'(MAX_LEN));
	assign r_wr   = accept && (mode == nmc_pkg::MODE_REFERENCE) && (rl_q < LEN_W'(MAX_LEN));

	// effective order from the saturated register and both lengths
	always_comb begin
		int mo, tm1, rm1, e;
		mo  = int'(max_order_q);
		tm1 = int'(tl_q) - 1;
		rm1 = int'(rl_q) - 1;
		if (mo > MAX_ORDER) mo = MAX_ORDER;
		e = mo;
		if (tm1 < e) e = tm1;
		if (rm1 < e) e = rm1;
		if (int'(tl_q) < 2 || int'(rl_q) < 2) e = 0;
		eff_calc = ORD_W'(e);
	end

	// compare step decisions
	always_comb begin
		t_ra     = AW'(LW1'(i_q) + LW1'(p_q));
		r_ra     = AW'(LW1'(j_q) + LW1'(p_q));
		mismatch = ((p_q == '0) && u_rd_q) || (t_rd_q != r_rd_q);
		p_last   = (LW1'(p_q) + LW1'(1) == LW1'(n_q));
		j_last   = (LW1'(j_q) + LW1'(n_q) == LW1'(rl_q));
		i_last   = (LW1'(i_q) + LW1'(n_q) == LW1'(tl_q));
		clr_last = (LW1'(clr_q) + LW1'(1) == LW1'(rl_q));
		hit_now  = (state_q == ST_CHK) && !mismatch && p_last;
		hits_nxt = hits_q + LEN_W'(hit_now);
		grams    = LEN_W'(LW1'(tl_q) + LW1'(1) - LW1'(n_q));
		u_we     = (state_q == ST_CLR) || hit_now;
		u_wa     = (state_q == ST_CLR) ? clr_q : j_q;
		u_wd     = (state_q != ST_CLR);
	end

	// token stores and used marks
	always_ff @(posedge clk) begin
		if (t_wr) t_mem[AW'(tl_q)] <= token;
		if (r_wr) r_mem[AW'(rl_q)] <= token;
		if (u_we) u_mem[u_wa] <= u_wd;
		t_rd_q <= t_mem[t_ra];
		r_rd_q <= r_mem[r_ra];
		u_rd_q <= u_mem[j_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_order_q <= nmc_pkg::MAX_ORDER_RESET;
		end else if (cfg_we) begin
			max_order_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tl_q         <= '0;
			rl_q         <= '0;
			ovf_q        <= 1'b0;
			eff_q        <= '0;
			n_q          <= '0;
			p_q          <= '0;
			i_q          <= '0;
			j_q          <= '0;
			clr_q        <= '0;
			hits_q       <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (t_wr) tl_q <= tl_q + LEN_W'(1);
						if (r_wr) rl_q <= rl_q + LEN_W'(1);
						if (accept && !t_wr && !r_wr) ovf_q <= 1'b1;
						if (mode == nmc_pkg::MODE_REFERENCE && end_of_sequence)
							state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					eff_q <= eff_calc;
					n_q   <= ORD_W'(1);
					clr_q <= '0;
					if (eff_calc == '0) begin
						result_valid <= 1'b1;
						tl_q         <= '0;
						rl_q         <= '0;
						ovf_q        <= 1'b0;
						state_q      <= ST_IDLE;
					end else begin
						state_q <= ST_CLR;
					end
				end
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_last) begin
						i_q     <= '0;
						j_q     <= '0;
						p_q     <= '0;
						hits_q  <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					hits_q <= hits_nxt;
					if (!mismatch && !p_last) begin
						p_q     <= p_q + ORD_W'(1);
						state_q <= ST_RD;
					end else if (!mismatch || j_last) begin
						// move to the next translation n-gram
						j_q <= '0;
						p_q <= '0;
						if (i_last) begin
							result_valid <= 1'b1;
							clr_q        <= '0;
							if (n_q == eff_q) begin
								tl_q    <= '0;
								rl_q    <= '0;
								ovf_q   <= 1'b0;
								state_q <= ST_IDLE;
							end else begin
								n_q     <= n_q + ORD_W'(1);
								state_q <= ST_CLR;
							end
						end else begin
							i_q     <= i_q + AW'(1);
							state_q <= ST_RD;
						end
					end else begin
						j_q     <= j_q + AW'(1);
						p_q     <= '0;
						state_q <= ST_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP) begin
			order              <= '0;
			matched_count      <= '0;
			ngram_count        <= '0;
			translation_length <= tl_q;
			reference_length   <= rl_q;
			overflowed         <= ovf_q;
			last_result        <= 1'b1;
		end else if (state_q == ST_CHK) begin
			order              <= n_q;
			matched_count      <= hits_nxt;
			ngram_count        <= grams;
			translation_length <= tl_q;
			reference_length   <= rl_q;
			overflowed         <= ovf_q;
			last_result        <= (n_q == eff_q);
		end
	end

	`NMC_ASSERT_NOW(a_last_frees, result_valid && last_result, !busy, "busy at last result")
	`NMC_ASSERT_NEXT(a_eos_busy, r_wr && end_of_sequence, busy, "no evaluation")
	`NMC_ASSERT_NOW(a_hits_bound, result_valid, matched_count <= ngram_count, "too many matches")
	`NMC_ASSERT_NOW(a_zero_last, result_valid && (order == '0), last_result, "order zero not last")
	`NMC_ASSERT_NOW(a_i_bound, state_q == ST_CHK, LW1'(i_q) + LW1'(n_q) <= LW1'(tl_q), "i range")
	`NMC_ASSERT_NOW(a_j_bound, state_q == ST_CHK, LW1'(j_q) + LW1'(n_q) <= LW1'(rl_q), "j range")

endmodule
